// ===== rtl/core/afre_pkg.sv =====
// Package for the audio fade ramp engine: opcodes, result codes, level limits,
// slot entry layout, controller states and the divider result bundle.
// No dependencies; every other file in rtl/core imports it.
package afre_pkg;

  // Command opcodes
  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_TICK      = 3'd1;
  localparam logic [2:0] OP_FIN_BANK  = 3'd2;
  localparam logic [2:0] OP_FIN_ALL   = 3'd3;
  localparam logic [2:0] OP_RESTART   = 3'd4;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd5;

  // Result codes
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_LEVEL  = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Level ceilings of the two banks
  localparam logic [15:0] VOL_MAX = 16'h7FFF;
  localparam logic [15:0] PAN_MAX = 16'd127;

  // Divider geometry: a 31-bit magnitude over a 16-bit length
  localparam int DVD_W     = 31;
  localparam int DVS_W     = 16;
  localparam int DIV_STEPS = 16;

  // One slot entry as held in the slot memory
  typedef struct packed {
    logic [15:0] snd;
    logic [14:0] lvl_start;
    logic [14:0] lvl_end;
    logic [15:0] cnt;
    logic [15:0] len;
  } ent_t;

  typedef struct packed {
    logic                 done;
    logic [DVS_W-1:0]     quo;
    logic                 rem_nz;
  } div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_LOAD,
    ST_DIVGO,
    ST_DIV,
    ST_EMIT,
    ST_BULK_RD,
    ST_BULK_WR
  } state_t;

endpackage

// ===== rtl/core/audio_fade_ramp_engine.sv =====
// Audio fade ramp engine: two banks of linear fade slots, one transaction at a time.
// Start: the acknowledgement is loaded from the start state, which then returns to idle.
// Tick: for each active slot that divides: scan, read and multiply, divider start, divider,
// write-back; a slot at its end level skips the divider start and the divider.
// Bulk commands read, then write back, each slot in turn; clear all acts at intake.
// Reset (synchronous, rst_n low) frees every slot; slot memory contents are don't-care.
module audio_fade_ramp_engine
  import afre_pkg::*;
#(
  parameter int SLOTS_PER_BANK = 5
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic        in_bank,
  input  logic [15:0] in_sound_id,
  input  logic [15:0] in_start_level,
  input  logic [15:0] in_end_level,
  input  logic [15:0] in_duration,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_status,
  output logic        out_bank_out,
  output logic [2:0]  out_slot,
  output logic [15:0] out_target_sound,
  output logic [14:0] out_level,
  output logic        out_last
);

  // Slots of both banks share one index space: volume bank first, then pan.
  localparam int NSLOT = 2 * SLOTS_PER_BANK;
  localparam int AW    = $clog2(NSLOT);
  localparam int IW    = $clog2(NSLOT + 1);
  localparam int SBW   = (SLOTS_PER_BANK > 1) ? $clog2(SLOTS_PER_BANK) : 1;

  // Saturate an incoming level to the ceiling of its bank.
  function automatic logic [14:0] sat_level(input logic [15:0] v, input logic pan);
    logic [15:0] maxv;
    maxv = pan ? PAN_MAX : VOL_MAX;
    return (v > maxv) ? maxv[14:0] : v[14:0];
  endfunction

  // -------------------------------------------------------------------------
  // Command capture. The controller takes a transaction only when idle. A
  // result held up by the receiver keeps the controller in the state that
  // produced it, so intake waits until the output register is free again.
  // -------------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic            in_acc;
  logic [2:0]      op_r;
  logic            bank_r;
  logic [15:0]     sound_r;
  logic [15:0]     lo_r;
  logic [15:0]     hi_r;
  logic [15:0]     dur_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_opcode;
      bank_r  <= in_bank;
      sound_r <= in_sound_id;
      lo_r    <= in_start_level;
      hi_r    <= in_end_level;
      dur_r   <= in_duration;
    end
  end

  // -------------------------------------------------------------------------
  // Slot state. The active flags live in flip-flops so that reset and clear
  // all free every slot at once. Everything else lives in the slot memory,
  // which needs no reset: a tick only reads an entry while its slot is
  // active, and a start rewrites the whole entry when it claims the slot.
  // -------------------------------------------------------------------------
  logic [NSLOT-1:0] active_r;
  ent_t             mem [NSLOT];
  ent_t             rd_q_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  ent_t             mem_wd;
  logic             mem_re;
  logic [AW-1:0]    mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_ra];
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  logic        out_valid_r;
  logic        out_free;
  logic        out_load;
  logic        kind_nxt, status_nxt, bank_nxt, last_nxt;
  logic [2:0]  slot_nxt;
  logic [15:0] sound_nxt;
  logic [14:0] level_nxt;
  logic        kind_r, status_r, bankq_r, last_r;
  logic [2:0]  slotq_r;
  logic [15:0] soundq_r;
  logic [14:0] levelq_r;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_r   <= kind_nxt;
      status_r <= status_nxt;
      bankq_r  <= bank_nxt;
      slotq_r  <= slot_nxt;
      soundq_r <= sound_nxt;
      levelq_r <= level_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_status       = status_r;
  assign out_bank_out     = bankq_r;
  assign out_slot         = slotq_r;
  assign out_target_sound = soundq_r;
  assign out_level        = levelq_r;
  assign out_last         = last_r;

  // -------------------------------------------------------------------------
  // Slot searches over the active flags
  // -------------------------------------------------------------------------
  logic [SLOTS_PER_BANK-1:0] bank_act;
  logic                      free_found;
  logic [SBW-1:0]            free_i;
  logic [AW-1:0]             free_j;
  logic [IW-1:0]             idx_r;
  logic [IW-1:0]             bulk_end_r;
  logic [AW-1:0]             cur_r;
  logic                      found;
  logic [AW-1:0]             fidx;
  logic                      more;

  // Lowest free slot of the chosen bank, for a start.
  always_comb begin
    bank_act   = bank_r ? active_r[NSLOT-1:SLOTS_PER_BANK]
                        : active_r[SLOTS_PER_BANK-1:0];
    free_found = 1'b0;
    free_i     = '0;
    for (int i = SLOTS_PER_BANK - 1; i >= 0; i--) begin
      if (!bank_act[i]) begin
        free_found = 1'b1;
        free_i     = SBW'(i);
      end
    end
    free_j = bank_r ? AW'(SLOTS_PER_BANK) + AW'(free_i) : AW'(free_i);
  end

  // Next active slot at or after the scan pointer, and whether another active
  // slot follows the one being emitted (this marks the last result of a tick).
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    more  = 1'b0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (active_r[i] && IW'(i) >= idx_r) begin
        found = 1'b1;
        fidx  = AW'(i);
      end
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (active_r[i] && AW'(i) > cur_r) begin
        more = 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Interpolation datapath: load the entry, form count * |end - start| in one
  // multiply, divide by the length in the shared divider, then apply the sign
  // with a floor correction and clamp.
  // -------------------------------------------------------------------------
  ent_t             ent_r;
  logic             neg_r;
  logic             special_r;
  logic [DVD_W-1:0] mag_r;
  logic             load_neg;
  logic [14:0]      load_absd;
  logic             load_special;
  logic             div_go;
  div_res_t         div_res;
  logic signed [17:0] qs;
  logic signed [17:0] lvl_sum;
  logic [14:0]      lvl;

  always_comb begin
    load_neg     = (rd_q_r.lvl_end < rd_q_r.lvl_start);
    load_absd    = load_neg ? (rd_q_r.lvl_start - rd_q_r.lvl_end)
                            : (rd_q_r.lvl_end - rd_q_r.lvl_start);
    load_special = (rd_q_r.len == '0) || (rd_q_r.cnt >= rd_q_r.len);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      ent_r     <= rd_q_r;
      neg_r     <= load_neg;
      special_r <= load_special;
      mag_r     <= DVD_W'(rd_q_r.cnt) * DVD_W'(load_absd);
    end
  end

  afre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (mag_r),
    .divisor  (ent_r.len),
    .res      (div_res)
  );

  // Count is below length here, so the quotient magnitude is below 2^15.
  always_comb begin
    if (neg_r) begin
      qs = -$signed({3'b000, div_res.quo[14:0]}) - $signed({17'd0, div_res.rem_nz});
    end else begin
      qs = $signed({3'b000, div_res.quo[14:0]});
    end
    lvl_sum = $signed({3'b000, ent_r.lvl_start}) + qs;
    if (special_r) begin
      lvl = ent_r.lvl_end;
    end else if (lvl_sum < 0) begin
      lvl = '0;
    end else if (lvl_sum > $signed({2'b00, VOL_MAX})) begin
      lvl = VOL_MAX[14:0];
    end else begin
      lvl = lvl_sum[14:0];
    end
  end

  // Bank and in-bank index of the slot being emitted.
  logic          cur_bank;
  logic [AW-1:0] cur_slot;

  assign cur_bank = (cur_r >= AW'(SLOTS_PER_BANK));
  assign cur_slot = cur_bank ? cur_r - AW'(SLOTS_PER_BANK) : cur_r;

  // -------------------------------------------------------------------------
  // Controller: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority case (in_opcode)
            OP_START:                         state_nxt = ST_START;
            OP_TICK:                          state_nxt = ST_SCAN;
            OP_FIN_BANK, OP_FIN_ALL,
            OP_RESTART:                       state_nxt = ST_BULK_RD;
            default:                          state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_START:   if (out_free) state_nxt = ST_IDLE;
      ST_SCAN:    state_nxt = found ? ST_LOAD : ST_IDLE;
      ST_LOAD:    state_nxt = load_special ? ST_EMIT : ST_DIVGO;
      ST_DIVGO:   state_nxt = ST_DIV;
      ST_DIV:     if (div_res.done) state_nxt = ST_EMIT;
      ST_EMIT:    if (out_free) state_nxt = ST_SCAN;
      ST_BULK_RD: state_nxt = ST_BULK_WR;
      ST_BULK_WR: state_nxt = (idx_r == bulk_end_r) ? ST_IDLE : ST_BULK_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Controller: outputs (memory ports, divider start, result payload)
  // -------------------------------------------------------------------------
  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = rd_q_r;
    mem_re     = 1'b0;
    mem_ra     = '0;
    div_go     = 1'b0;
    out_load   = 1'b0;
    kind_nxt   = KIND_LEVEL;
    status_nxt = STATUS_OK;
    bank_nxt   = cur_bank;
    slot_nxt   = 3'(cur_slot);
    sound_nxt  = ent_r.snd;
    level_nxt  = lvl;
    last_nxt   = !more;
    unique case (state_r)
      ST_START: begin
        out_load         = out_free;
        mem_we           = out_free && free_found;
        mem_wa           = free_j;
        mem_wd.snd       = sound_r;
        mem_wd.lvl_start = sat_level(lo_r, bank_r);
        mem_wd.lvl_end   = sat_level(hi_r, bank_r);
        mem_wd.cnt       = '0;
        mem_wd.len       = dur_r;
        kind_nxt         = KIND_ACK;
        status_nxt       = free_found ? STATUS_OK : STATUS_FULL;
        bank_nxt         = bank_r;
        slot_nxt         = free_found ? 3'(free_i) : 3'd0;
        sound_nxt        = sound_r;
        level_nxt        = '0;
        last_nxt         = 1'b1;
      end
      ST_SCAN: begin
        mem_re = found;
        mem_ra = fidx;
      end
      ST_DIVGO: begin
        div_go = 1'b1;
      end
      ST_EMIT: begin
        // A slot that has reached its length is freed through its active flag;
        // otherwise the count steps on.
        out_load   = out_free;
        mem_we     = out_free && !special_r;
        mem_wa     = cur_r;
        mem_wd     = ent_r;
        mem_wd.cnt = ent_r.cnt + 16'd1;
      end
      ST_BULK_RD: begin
        mem_re = 1'b1;
        mem_ra = idx_r[AW-1:0];
      end
      ST_BULK_WR: begin
        mem_we         = 1'b1;
        mem_wa         = idx_r[AW-1:0];
        mem_wd         = rd_q_r;
        mem_wd.lvl_end = '0;
        if (op_r == OP_RESTART) begin
          mem_wd.cnt = '0;
          mem_wd.len = dur_r;
        end else begin
          mem_wd.cnt = rd_q_r.len;
        end
      end
      ST_IDLE, ST_LOAD, ST_DIV: begin
      end
      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Controller registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_opcode == OP_CLEAR_ALL) begin
        active_r <= '0;
      end else if (state_r == ST_START && out_free && free_found) begin
        active_r[free_j] <= 1'b1;
      end else if (state_r == ST_EMIT && out_free && special_r) begin
        active_r[cur_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_opcode == OP_FIN_BANK && in_bank) begin
        idx_r      <= IW'(SLOTS_PER_BANK);
        bulk_end_r <= IW'(NSLOT - 1);
      end else if (in_opcode == OP_FIN_BANK) begin
        idx_r      <= '0;
        bulk_end_r <= IW'(SLOTS_PER_BANK - 1);
      end else begin
        idx_r      <= '0;
        bulk_end_r <= IW'(NSLOT - 1);
      end
    end else if (state_r == ST_SCAN && found) begin
      cur_r <= fidx;
    end else if (state_r == ST_EMIT && out_free) begin
      idx_r <= IW'(cur_r) + IW'(1);
    end else if (state_r == ST_BULK_WR) begin
      idx_r <= idx_r + IW'(1);
    end
  end

endmodule

// ===== rtl/core/afre_div.sv =====
// Radix-2 restoring divider for the ramp interpolation, one quotient bit per cycle.
// Depends on afre_pkg for widths and the result bundle.
module afre_div
  import afre_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_res_t         res
);

  logic             busy_r;
  logic             done_r;
  logic [4:0]       step_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVS_W-1:0] qt_r;
  logic [DVS_W-1:0] qt_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic             qbit;

  // The caller guarantees the quotient fits in DVS_W bits, so the upper half
  // of the dividend is already below the divisor.
  always_comb begin
    trial = {rem_r, qt_r[DVS_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      qbit    = 1'b1;
      rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
    end else begin
      qbit    = 1'b0;
      rem_nxt = trial[DVS_W-1:0];
    end
    qt_nxt = {qt_r[DVS_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= 5'(DIV_STEPS);
    end else if (busy_r) begin
      step_r <= step_r - 5'd1;
      if (step_r == 5'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= {1'b0, dividend[DVD_W-1:DVS_W]};
      qt_r  <= dividend[DVS_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      qt_r  <= qt_nxt;
    end
  end

  assign res.done   = done_r;
  assign res.quo    = qt_r;
  assign res.rem_nz = (rem_r != '0);

endmodule

// ===== test/fade_ramp_checker.sv =====
// Checker for the audio fade ramp engine: watches both channels, predicts the
// acknowledgements and level updates of each command and compares them in order.
// Depends on afre_pkg for the opcodes, result codes and level ceilings.
module fade_ramp_checker
  import afre_pkg::*;
#(
  parameter int SLOTS_PER_BANK = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic        in_bank,
  input  logic [15:0] in_sound_id,
  input  logic [15:0] in_start_level,
  input  logic [15:0] in_end_level,
  input  logic [15:0] in_duration,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic        out_status,
  input  logic        out_bank_out,
  input  logic [2:0]  out_slot,
  input  logic [15:0] out_target_sound,
  input  logic [14:0] out_level,
  input  logic        out_last,
  output int          mismatches,
  output int          results_pending,
  output int          results_checked
);

  localparam int FADES = 2 * SLOTS_PER_BANK;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic        bank;
    logic [2:0]  slot;
    logic [15:0] sound;
    logic [14:0] level;
    logic        last;
  } fade_result_t;

  // Shadow copy of the slot memory.
  logic        fade_busy   [FADES];
  logic [15:0] fade_handle [FADES];
  logic [14:0] fade_from   [FADES];
  logic [14:0] fade_to     [FADES];
  logic [15:0] fade_step   [FADES];
  logic [15:0] fade_len    [FADES];

  fade_result_t expected_results[$];

  function automatic logic [14:0] ramp_point(input int idx);
    longint from_lvl, to_lvl, len, pos, num, quo, lvl;
    from_lvl = fade_from[idx];
    to_lvl   = fade_to[idx];
    len      = fade_len[idx];
    pos      = fade_step[idx];
    if (len == 0 || pos >= len) begin
      lvl = to_lvl;
    end else begin
      num = pos * (to_lvl - from_lvl);
      quo = num / len;
      // Division truncates towards zero; a falling ramp must round down.
      if (num % len != 0 && num < 0) begin
        quo = quo - 1;
      end
      lvl = from_lvl + quo;
    end
    if (lvl < 0) begin
      lvl = 0;
    end
    if (lvl > longint'(VOL_MAX)) begin
      lvl = longint'(VOL_MAX);
    end
    return lvl[14:0];
  endfunction

  task automatic free_fade(input int idx);
    fade_busy[idx]   = 1'b0;
    fade_handle[idx] = '0;
    fade_from[idx]   = '0;
    fade_to[idx]     = '0;
    fade_step[idx]   = '0;
    fade_len[idx]    = '0;
  endtask

  task automatic apply_command(input logic [2:0] op, input logic bank,
                               input logic [15:0] sound, input logic [15:0] lo,
                               input logic [15:0] hi, input logic [15:0] dur);
    int           base;
    int           active;
    int           emitted;
    logic         claimed;
    logic [15:0]  ceiling;
    fade_result_t r;
    base    = bank ? SLOTS_PER_BANK : 0;
    ceiling = bank ? PAN_MAX : VOL_MAX;
    active  = 0;
    emitted = 0;
    claimed = 1'b0;
    case (op)
      OP_START: begin
        r.kind   = KIND_ACK;
        r.status = STATUS_FULL;
        r.bank   = bank;
        r.slot   = 3'd0;
        r.sound  = sound;
        r.level  = '0;
        r.last   = 1'b1;
        for (int i = 0; i < SLOTS_PER_BANK; i++) begin
          if (!claimed && !fade_busy[base + i]) begin
            claimed                = 1'b1;
            fade_busy[base + i]    = 1'b1;
            fade_handle[base + i]  = sound;
            fade_from[base + i]    = (lo > ceiling) ? ceiling[14:0] : lo[14:0];
            fade_to[base + i]      = (hi > ceiling) ? ceiling[14:0] : hi[14:0];
            fade_step[base + i]    = '0;
            fade_len[base + i]     = dur;
            r.status               = STATUS_OK;
            r.slot                 = 3'(i);
          end
        end
        expected_results.push_back(r);
      end
      OP_TICK: begin
        for (int i = 0; i < FADES; i++) begin
          if (fade_busy[i]) begin
            active++;
          end
        end
        for (int i = 0; i < FADES; i++) begin
          if (fade_busy[i]) begin
            r.kind   = KIND_LEVEL;
            r.status = STATUS_OK;
            r.bank   = (i >= SLOTS_PER_BANK);
            r.slot   = 3'(i % SLOTS_PER_BANK);
            r.sound  = fade_handle[i];
            r.level  = ramp_point(i);
            r.last   = (emitted == active - 1);
            expected_results.push_back(r);
            emitted++;
            if (fade_step[i] >= fade_len[i]) begin
              free_fade(i);
            end else begin
              fade_step[i] = fade_step[i] + 16'd1;
            end
          end
        end
      end
      OP_FIN_BANK: begin
        for (int i = 0; i < SLOTS_PER_BANK; i++) begin
          fade_to[base + i]   = '0;
          fade_step[base + i] = fade_len[base + i];
        end
      end
      OP_FIN_ALL: begin
        for (int i = 0; i < FADES; i++) begin
          fade_to[i]   = '0;
          fade_step[i] = fade_len[i];
        end
      end
      OP_RESTART: begin
        for (int i = 0; i < FADES; i++) begin
          fade_step[i] = '0;
          fade_len[i]  = dur;
          fade_to[i]   = '0;
        end
      end
      OP_CLEAR_ALL: begin
        for (int i = 0; i < FADES; i++) begin
          free_fade(i);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: result %0d, %s expected %0h, got %0h",
               $time, results_checked, name, want, got);
    end
  endtask

  task automatic check_result();
    fade_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected (kind %0h bank %0h slot %0h level %0h)",
               $time, out_kind, out_bank_out, out_slot, out_level);
    end else begin
      want = expected_results.pop_front();
      compare_field("kind",   want.kind,   out_kind);
      compare_field("status", want.status, out_status);
      compare_field("bank",   want.bank,   out_bank_out);
      compare_field("slot",   want.slot,   out_slot);
      compare_field("sound",  want.sound,  out_target_sound);
      compare_field("level",  want.level,  out_level);
      compare_field("last",   want.last,   out_last);
    end
    results_checked++;
  endtask

  initial begin
    mismatches      = 0;
    results_pending = 0;
    results_checked = 0;
    for (int i = 0; i < FADES; i++) begin
      free_fade(i);
    end
  end

  // Commands are taken before results, so a result in the same cycle as its
  // own command would still find its expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FADES; i++) begin
        free_fade(i);
      end
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(in_opcode, in_bank, in_sound_id, in_start_level,
                      in_end_level, in_duration);
      end
      if (out_valid && !out_stall) begin
        check_result();
      end
    end
    results_pending = expected_results.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the fade ramp engine testbench: clock, reset, command stimulus, result
// back-pressure and the verdict. Depends on afre_pkg, audio_fade_ramp_engine and
// fade_ramp_checker.
module testbench;
  import afre_pkg::*;

  localparam int SLOTS        = 5;
  localparam int RANDOM_ITEMS = 230;
  localparam int CYCLE_LIMIT  = 1000000;
  // The tail gives a tick over all ten busy slots room to finish
  // before the verdict is given.
  localparam int TAIL_CYCLES  = 300;

  // Opcodes the block has no use for; they must be swallowed silently.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_opcode;
  logic        in_bank;
  logic [15:0] in_sound_id;
  logic [15:0] in_start_level;
  logic [15:0] in_end_level;
  logic [15:0] in_duration;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic        out_status;
  logic        out_bank_out;
  logic [2:0]  out_slot;
  logic [15:0] out_target_sound;
  logic [14:0] out_level;
  logic        out_last;

  int mismatches;
  int results_pending;
  int results_checked;

  int cycle_count = 0;
  int starts_sent = 0;
  int ticks_sent  = 0;
  int bulk_sent   = 0;
  int spare_sent  = 0;

  // Set by the stimulus to make the receiver hold off for that many cycles.
  int   receiver_hold_cycles = 0;
  // While set, neither side idles: back-to-back transactions in both directions.
  logic steady = 1'b0;

  audio_fade_ramp_engine #(.SLOTS_PER_BANK(SLOTS)) uut (.*);

  fade_ramp_checker #(.SLOTS_PER_BANK(SLOTS)) u_checker (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, results_pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stall lengths: one in ten is drawn from the long range, the rest are short.
  function automatic int pick_stall();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  // Gaps between commands: often none at all, sometimes short, rarely long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 9);
    if (steady || roll < 6) begin
      return 0;
    end
    if (roll < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(15, 50);
  endfunction

  // Levels spread over the whole input range, with plenty near the bank
  // ceiling so that saturation is exercised from both sides.
  function automatic logic [15:0] pick_level(input logic bank);
    logic [15:0] ceiling;
    ceiling = bank ? PAN_MAX : VOL_MAX;
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, ceiling));
      2:       return $urandom_range(0, 1) ? ceiling : 16'h0000;
      default: return 16'hFFFF - 16'($urandom_range(0, 3));
    endcase
  endfunction

  // Short ramps keep slots turning over; a few very long ones stay parked
  // until a finish or a clear sweeps them away.
  function automatic logic [15:0] pick_duration();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 16) begin
      return 16'($urandom_range(0, 12));
    end
    if (roll < 19) begin
      return 16'($urandom_range(13, 300));
    end
    return 16'($urandom);
  endfunction

  // Offers one command and holds it steady until the block accepts it. The
  // valid line is left high so that a following command can go out at once.
  task automatic issue_command(input logic [2:0] op, input logic bank,
                               input logic [15:0] sound, input logic [15:0] lo,
                               input logic [15:0] hi, input logic [15:0] dur);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_bank        <= bank;
    in_sound_id    <= sound;
    in_start_level <= lo;
    in_end_level   <= hi;
    in_duration    <= dur;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    case (op)
      OP_START:  starts_sent++;
      OP_TICK:   ticks_sent++;
      OP_SPARE_A,
      OP_SPARE_B: spare_sent++;
      default:   bulk_sent++;
    endcase
  endtask

  task automatic sender_pause(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stops offering commands until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic random_command(output logic counted);
    int          roll;
    logic        bank;
    logic [15:0] dur;
    roll    = $urandom_range(0, 99);
    bank    = 1'($urandom_range(0, 1));
    dur     = pick_duration();
    counted = 1'b1;
    if (roll < 40) begin
      issue_command(OP_START, bank, 16'($urandom), pick_level(bank), pick_level(bank), dur);
    end else if (roll < 78) begin
      issue_command(OP_TICK, bank, 16'($urandom), 16'($urandom), 16'($urandom), dur);
    end else if (roll < 84) begin
      issue_command(OP_FIN_BANK, bank, 16'($urandom), 16'($urandom), 16'($urandom), dur);
    end else if (roll < 88) begin
      issue_command(OP_FIN_ALL, bank, 16'($urandom), 16'($urandom), 16'($urandom), dur);
    end else if (roll < 93) begin
      issue_command(OP_RESTART, bank, 16'($urandom), 16'($urandom), 16'($urandom), dur);
    end else if (roll < 96) begin
      issue_command(OP_CLEAR_ALL, bank, 16'($urandom), 16'($urandom), 16'($urandom), dur);
    end else begin
      // Spare opcodes are pure noise and do not count towards the item total.
      counted = 1'b0;
      issue_command($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, bank,
                    16'($urandom), 16'($urandom), 16'($urandom), dur);
    end
  endtask

  // Receiver: random back-pressure, plus the long hold-off on request. Each
  // pass assigns out_stall once and then waits on the clock.
  initial begin : receiver
    int span;
    forever begin
      if (receiver_hold_cycles > 0) begin
        span = receiver_hold_cycles;
        receiver_hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end else if (!steady && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_stall()) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int   random_sent;
    logic counted;
    random_sent    = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_TICK;
    in_bank        <= 1'b0;
    in_sound_id    <= '0;
    in_start_level <= '0;
    in_end_level   <= '0;
    in_duration    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. A tick with nothing running must produce nothing.
    issue_command(OP_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    sender_pause(pick_gap());
    // Volume ramp falling from a saturated start, and one of zero length
    // which lands on its end level at once and frees itself.
    issue_command(OP_START, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd4);
    issue_command(OP_START, 1'b0, 16'h0000, 16'h0000, 16'h7FFF, 16'd0);
    // Pan ramps with levels above the pan ceiling, one of maximal length.
    issue_command(OP_START, 1'b1, 16'h8001, 16'h8000, 16'd5, 16'd3);
    issue_command(OP_START, 1'b1, 16'h7FFE, 16'h0000, 16'hFFFF, 16'hFFFF);
    sender_pause(pick_gap());
    issue_command(OP_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // The two spare opcodes, with every other field busy.
    issue_command(OP_SPARE_A, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue_command(OP_SPARE_B, 1'b0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    // Fill the pan bank, then one start too many is refused.
    for (int i = 0; i < 4; i++) begin
      issue_command(OP_START, 1'b1, 16'($urandom), pick_level(1'b1), pick_level(1'b1),
                    16'(2 + i));
    end
    // Fill the volume bank likewise; the last start finds it full.
    for (int i = 0; i < 5; i++) begin
      issue_command(OP_START, 1'b0, 16'($urandom), pick_level(1'b0), pick_level(1'b0),
                    16'(3 + i));
    end
    sender_pause(pick_gap());
    // Every slot busy: one tick with the most results a command can give.
    issue_command(OP_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue_command(OP_FIN_BANK, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue_command(OP_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // Restart bends every remaining ramp towards zero over two ticks.
    issue_command(OP_RESTART, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'd2);
    issue_command(OP_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue_command(OP_FIN_ALL, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue_command(OP_TICK, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue_command(OP_CLEAR_ALL, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue_command(OP_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    drain_results();

    // Random part, with one pressure episode and a steady stretch inside it.
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent == 80) begin
        // Load up the volume bank, then stop taking results for a long while
        // and keep ticking, so that the block backs up and stalls its input.
        issue_command(OP_CLEAR_ALL, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i < SLOTS; i++) begin
          issue_command(OP_START, 1'b0, 16'($urandom), pick_level(1'b0), pick_level(1'b0),
                        16'd40);
        end
        receiver_hold_cycles = 500;
        for (int i = 0; i < 6; i++) begin
          issue_command(OP_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        end
        // The sender now waits for the receiver to catch up completely.
        drain_results();
      end
      steady = (random_sent >= 140 && random_sent < 180);
      random_command(counted);
      if (counted) begin
        random_sent++;
      end
      sender_pause(pick_gap());
    end
    steady = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d starts, %0d ticks, %0d bulk commands and %0d spare opcodes,",
             starts_sent, ticks_sent, bulk_sent, spare_sent);
    $display("checking %0d acknowledgements and level updates in %0d cycles.",
             results_checked, cycle_count);
    if (results_pending != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_pending);
    end
    if (mismatches == 0 && results_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/afre_pkg.sv
rtl/core/afre_div.sv
rtl/core/audio_fade_ramp_engine.sv
test/fade_ramp_checker.sv
test/testbench.sv
